FILE: rtl/core/csep_pkg.sv
// ----------------------------------------------------------------------------
// csep_pkg
// Shared types, widths and status codes of the class separation score block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csep_pkg;

    localparam int SAMPLES  = 1024;
    localparam int ADDR_W   = $clog2(SAMPLES);
    localparam int CNT_W    = $clog2(SAMPLES + 1);
    localparam int CLASSES  = 16;
    localparam int LABEL_W  = 4;
    localparam int CLS_W    = 5;
    localparam int VALUE_W  = 16;
    localparam int SUM_W    = VALUE_W + ADDR_W;
    localparam int MEAN_W   = VALUE_W + 9;
    localparam int MAG_W    = MEAN_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int ACC_W    = 64;
    localparam int FRAC_W   = 16;
    localparam int SCORE_W  = 32;
    localparam int MNUM_W   = SUM_W + 8;
    localparam int RNUM_W   = ACC_W + FRAC_W;
    localparam int STATUS_W = 3;

    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LABEL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MANY  = 3'd4;

    typedef struct packed {
        logic [LABEL_W-1:0]        label;
        logic signed [VALUE_W-1:0] sample_value;
        logic                      last;
    } in_t;

    typedef struct packed {
        logic [SCORE_W-1:0]  score;
        logic [STATUS_W-1:0] status;
    } out_t;

    typedef struct packed {
        logic                load;
        logic                clear;
        logic                div_start;
        logic                div_ovr;
        logic                wr_overall;
        logic                wr_mean;
        logic [CLS_W-1:0]    cls_idx;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                ratio_start;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
    } cmd_t;

    typedef struct packed {
        logic             bad_flag;
        logic             many_flag;
        logic [CNT_W-1:0] seen;
        logic [CLS_W-1:0] classes;
        logic             cls_empty;
        logic             div_done;
        logic             pipe_busy;
        logic             within_zero;
        logic             ratio_done;
        logic             out_full;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/class_separation_score.sv
// ----------------------------------------------------------------------------
// class_separation_score
// Between over within class scatter ratio of a labelled sample set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle and stored; the item marked last starts the
// evaluation. That computes the overall mean and then the mean of each class
// (one shared bit-serial mean divider), makes the scatter pass over the stored
// samples (one memory read port), drains the squaring pipe, and runs the
// bit-serial ratio divider. Input is held off during evaluation; a result
// waiting on the output does not stop the next set from loading.
`timescale 1ns / 1ps
`default_nettype none

module class_separation_score (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire csep_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output csep_pkg::out_t      m_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [4:0]     cfg_data
);

    csep_pkg::cmd_t cmd;
    csep_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    csep_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_last  (s_data.last),
        .sts     (sts),
        .cmd     (cmd)
    );

    csep_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/csep_div.sv
// ----------------------------------------------------------------------------
// csep_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csep_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 11
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo
);

    localparam int C_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg;
    logic [C_W-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   r_shift;
    logic [DEN_W:0]   r_diff;

    assign r_shift = {r_reg, q_reg[NUM_W-1]};
    assign r_diff  = r_shift - {1'b0, d_reg};

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = C_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!r_diff[DEN_W]) begin
                r_next = r_diff[DEN_W-1:0];
            end else begin
                r_next = r_shift[DEN_W-1:0];
            end
            q_next   = {q_reg[NUM_W-2:0], ~r_diff[DEN_W]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == C_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        if (start) begin
            d_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

FILE: rtl/core/csep_dp.sv
// ----------------------------------------------------------------------------
// csep_dp
// Datapath: sample store, class accumulators, mean divider, squaring pipe,
// ratio divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csep_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire csep_pkg::in_t        s_data,
    input  wire logic                 cfg_valid,
    input  wire logic [4:0]           cfg_data,
    input  wire csep_pkg::cmd_t       cmd,
    output csep_pkg::sts_t            sts,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output csep_pkg::out_t            m_data
);

    localparam int ADDR_W = csep_pkg::ADDR_W;
    localparam int CNT_W  = csep_pkg::CNT_W;
    localparam int NCLS   = csep_pkg::CLASSES;
    localparam int LAB_W  = csep_pkg::LABEL_W;
    localparam int CLS_W  = csep_pkg::CLS_W;
    localparam int VAL_W  = csep_pkg::VALUE_W;
    localparam int SUM_W  = csep_pkg::SUM_W;
    localparam int MEAN_W = csep_pkg::MEAN_W;
    localparam int MAG_W  = csep_pkg::MAG_W;
    localparam int SQ_W   = csep_pkg::SQ_W;
    localparam int ACC_W  = csep_pkg::ACC_W;
    localparam int MNUM_W = csep_pkg::MNUM_W;
    localparam int RNUM_W = csep_pkg::RNUM_W;
    localparam int SC_W   = csep_pkg::SCORE_W;

    logic [CLS_W-1:0]        num_classes_reg;
    logic [CLS_W-1:0]        classes;
    logic [CNT_W-1:0]        count_reg [NCLS];
    logic signed [SUM_W-1:0] sum_reg [NCLS];
    logic signed [SUM_W-1:0] grand_reg;
    logic [CNT_W-1:0]        seen_reg;
    logic [1:0]              flags_reg;
    logic                    bad;
    logic                    many;
    logic                    take;

    logic [LAB_W-1:0]        mem_lab [csep_pkg::SAMPLES];
    logic signed [VAL_W-1:0] mem_val [csep_pkg::SAMPLES];
    logic [LAB_W-1:0]        rd_lab_reg;
    logic signed [VAL_W-1:0] rd_val_reg;
    logic                    rd_v_reg;

    logic [LAB_W-1:0]         ci;
    logic signed [SUM_W-1:0]  dsum;
    logic [CNT_W-1:0]         dden;
    logic [SUM_W-1:0]         dmag;
    logic                     neg_reg;
    logic                     mdone;
    logic [MNUM_W-1:0]        mquo;
    logic signed [MEAN_W-1:0] mean_q;
    logic signed [MEAN_W-1:0] overall_reg;
    logic signed [MEAN_W-1:0] means_reg [NCLS];

    logic signed [MEAN_W-1:0] op_a, op_b;
    logic signed [MEAN_W:0]   diff;
    logic [MAG_W-1:0]         mag_reg;
    logic                     s1_v_reg, s1_t_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     s2_v_reg, s2_t_reg;
    logic [ACC_W-1:0]         between_reg, within_reg;

    logic                     rdone;
    logic [RNUM_W-1:0]        rquo;
    logic [SC_W-1:0]          score_sel;
    logic                     m_valid_reg;
    csep_pkg::out_t           m_data_reg;

    assign classes = (num_classes_reg > CLS_W'(NCLS)) ? CLS_W'(NCLS) : num_classes_reg;
    assign bad     = {1'b0, s_data.label} >= classes;
    assign many    = seen_reg == CNT_W'(csep_pkg::SAMPLES);
    assign take    = cmd.load && !bad && !many;
    assign ci      = cmd.cls_idx[LAB_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= CLS_W'(2);
        end else if (cfg_valid) begin
            num_classes_reg <= cfg_data;
        end
    end

    // class accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            for (int c = 0; c < NCLS; c++) begin
                count_reg[c] <= '0;
                sum_reg[c]   <= '0;
            end
            grand_reg <= '0;
            seen_reg  <= '0;
            flags_reg <= '0;
        end else if (cmd.load) begin
            if (bad) begin
                flags_reg[0] <= 1'b1;
            end else if (many) begin
                flags_reg[1] <= 1'b1;
            end else begin
                count_reg[s_data.label] <= count_reg[s_data.label] + 1'b1;
                sum_reg[s_data.label]   <= sum_reg[s_data.label]
                                           + SUM_W'(s_data.sample_value);
                grand_reg               <= grand_reg + SUM_W'(s_data.sample_value);
                seen_reg                <= seen_reg + 1'b1;
            end
        end
    end

    // sample store
    always_ff @(posedge aclk) begin
        if (take) begin
            mem_lab[seen_reg[ADDR_W-1:0]] <= s_data.label;
            mem_val[seen_reg[ADDR_W-1:0]] <= s_data.sample_value;
        end
        if (cmd.rd_en) begin
            rd_lab_reg <= mem_lab[cmd.rd_addr];
            rd_val_reg <= mem_val[cmd.rd_addr];
        end
    end

    // mean divider
    assign dsum = cmd.div_ovr ? grand_reg : sum_reg[ci];
    assign dden = cmd.div_ovr ? seen_reg : count_reg[ci];
    assign dmag = dsum[SUM_W-1] ? SUM_W'(-dsum) : SUM_W'(dsum);

    csep_div #(
        .NUM_W (MNUM_W),
        .DEN_W (CNT_W)
    ) u_mdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     ({dmag, 8'b0}),
        .den     (dden),
        .done    (mdone),
        .quo     (mquo)
    );

    assign mean_q = neg_reg ? -$signed(mquo[MEAN_W-1:0]) : $signed(mquo[MEAN_W-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= dsum[SUM_W-1];
        end
        if (cmd.wr_overall) begin
            overall_reg <= mean_q;
        end
        if (cmd.wr_mean) begin
            means_reg[ci] <= mean_q;
        end
    end

    // squared difference pipe
    always_comb begin
        if (rd_v_reg) begin
            op_a = means_reg[rd_lab_reg];
            op_b = MEAN_W'($signed({rd_val_reg, 8'b0}));
        end else begin
            op_a = overall_reg;
            op_b = mean_q;
        end
        diff = {op_a[MEAN_W-1], op_a} - {op_b[MEAN_W-1], op_b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= cmd.rd_en;
            s1_v_reg <= rd_v_reg || cmd.wr_mean;
            s2_v_reg <= s1_v_reg;
        end
        s1_t_reg <= rd_v_reg;
        mag_reg  <= diff[MEAN_W] ? MAG_W'(-diff) : MAG_W'(diff);
        s2_t_reg <= s1_t_reg;
        sq_reg   <= mag_reg * mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            between_reg <= '0;
            within_reg  <= '0;
        end else if (s2_v_reg) begin
            if (s2_t_reg) begin
                within_reg <= within_reg + ACC_W'(sq_reg);
            end else begin
                between_reg <= between_reg + ACC_W'(sq_reg);
            end
        end
    end

    // ratio divider
    csep_div #(
        .NUM_W (RNUM_W),
        .DEN_W (ACC_W)
    ) u_rdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.ratio_start),
        .num     ({between_reg, 16'b0}),
        .den     (within_reg),
        .done    (rdone),
        .quo     (rquo)
    );

    always_comb begin
        if (cmd.out_status != csep_pkg::ST_OK) begin
            score_sel = '0;
        end else if (|rquo[RNUM_W-1:SC_W]) begin
            score_sel = '1;
        end else begin
            score_sel = rquo[SC_W-1:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            m_data_reg.score  <= score_sel;
            m_data_reg.status <= cmd.out_status;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.bad_flag    = flags_reg[0];
    assign sts.many_flag   = flags_reg[1];
    assign sts.seen        = seen_reg;
    assign sts.classes     = classes;
    assign sts.cls_empty   = count_reg[ci] == '0;
    assign sts.div_done    = mdone;
    assign sts.pipe_busy   = rd_v_reg || s1_v_reg || s2_v_reg;
    assign sts.within_zero = within_reg == '0;
    assign sts.ratio_done  = rdone;
    assign sts.out_full    = m_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/core/csep_ctrl.sv
// ----------------------------------------------------------------------------
// csep_ctrl
// Controller: sample loading, mean loop, scatter pass, ratio and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csep_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_last,
    input  wire csep_pkg::sts_t sts,
    output csep_pkg::cmd_t      cmd
);

    localparam int CNT_W = csep_pkg::CNT_W;
    localparam int CLS_W = csep_pkg::CLS_W;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_OVR    = 4'd2;
    localparam logic [3:0] S_CLS    = 4'd3;
    localparam logic [3:0] S_CWAIT  = 4'd4;
    localparam logic [3:0] S_WITHIN = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_RATIO  = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [CLS_W-1:0]              cls_reg, cls_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [csep_pkg::STATUS_W-1:0] st_reg, st_next;

    always_comb begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        idx_next       = idx_reg;
        st_next        = st_reg;
        cmd            = '0;
        cmd.cls_idx    = cls_reg;
        cmd.rd_addr    = idx_reg[csep_pkg::ADDR_W-1:0];
        cmd.out_status = st_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_last) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (sts.bad_flag) begin
                    st_next    = csep_pkg::ST_LABEL;
                    state_next = S_FIN;
                end else if (sts.many_flag) begin
                    st_next    = csep_pkg::ST_MANY;
                    state_next = S_FIN;
                end else if (sts.seen == '0) begin
                    st_next    = csep_pkg::ST_EMPTY;
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_ovr   = 1'b1;
                    state_next    = S_OVR;
                end
            end
            S_OVR: begin
                cmd.div_ovr = 1'b1;
                if (sts.div_done) begin
                    cmd.wr_overall = 1'b1;
                    cls_next       = '0;
                    state_next     = S_CLS;
                end
            end
            S_CLS: begin
                priority if (cls_reg == sts.classes) begin
                    idx_next   = '0;
                    state_next = S_WITHIN;
                end else if (sts.cls_empty) begin
                    st_next    = csep_pkg::ST_EMPTY;
                    state_next = S_FIN;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_CWAIT;
                end
            end
            S_CWAIT: begin
                if (sts.div_done) begin
                    cmd.wr_mean = 1'b1;
                    cls_next    = cls_reg + 1'b1;
                    state_next  = S_CLS;
                end
            end
            S_WITHIN: begin
                if (idx_reg < sts.seen) begin
                    cmd.rd_en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    if (sts.within_zero) begin
                        st_next    = csep_pkg::ST_ZERO;
                        state_next = S_FIN;
                    end else begin
                        cmd.ratio_start = 1'b1;
                        state_next      = S_RATIO;
                    end
                end
            end
            S_RATIO: begin
                if (sts.ratio_done) begin
                    st_next    = csep_pkg::ST_OK;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!sts.out_full) begin
                    cmd.out_load = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
        cls_reg <= cls_next;
        idx_reg <= idx_next;
        st_reg  <= st_next;
    end

endmodule

`default_nettype wire
